// ===== hw/rtl/periodic_task_tick_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_assert
// assertion macros shared by the scheduler rtl, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PTTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// op codes, field widths and sequencer states of the tick scheduler
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int OP_W   = 3;
  localparam int TIDX_W = 3;
  localparam int TIME_W = 16;
  localparam int FIRE_W = 8;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUSPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_RESUME  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/periodic_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// table of periodic task slots, walked one slot per cycle on every tick
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one request per accepted item: tick, create, suspend, resume or
//           delete, with slot index, period and first delay for create.
//   out_* : one result per request: fire mask (ticks only) and accepted flag.
// sequencing:
//   suspend, resume, delete, create and unused codes: the table update is done
//   in the accept cycle, then ST_DONE moves the result into the output register
//   once it is free; no new request is taken until that is done.
//   tick: one slot per cycle through the period/countdown ram (registered
//   read, read of the next slot overlapped with the write-back of the last),
//   then on through ST_DONE like the other codes.
// reset: all slots free and suspended, countdowns read as zero; no clearing
//   pass, a per-slot written mark masks never-written ram entries.
// stall: the output register holds its result while out_ready is low; the
//   next request is still accepted and worked, and waits before delivery.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
  parameter int TASKS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ptts_pkg::OP_W-1:0]   in_op,
  input  logic [ptts_pkg::TIDX_W-1:0] in_task_index,
  input  logic [ptts_pkg::TIME_W-1:0] in_period,
  input  logic [ptts_pkg::TIME_W-1:0] in_first_delay,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ptts_pkg::FIRE_W-1:0] out_fire_mask,
  output logic                       out_accepted
);

  import ptts_pkg::*;

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CNT_W = $clog2(TASKS + 1);
  localparam int EXT_W = (IDX_W > TIDX_W) ? IDX_W : TIDX_W;
  localparam int WORD_W = 2 * TIME_W;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic                 p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]     p_idx_r, p_idx_nxt;
  logic [FIRE_W-1:0]    mask_r, mask_nxt;
  logic                 res_acc_r, res_acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [FIRE_W-1:0]    out_fire_mask_r, out_fire_mask_nxt;
  logic                 out_accepted_r, out_accepted_nxt;
  logic [TASKS-1:0]     slot_valid_r, slot_valid_nxt;
  logic [TASKS-1:0]     slot_run_r, slot_run_nxt;
  logic [TASKS-1:0]     slot_wr_r, slot_wr_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  logic [EXT_W-1:0]     idx_ext;
  logic [IDX_W-1:0]     slot_sel;
  logic                 in_range;
  logic [TIME_W-1:0]    cur_cd;
  logic [TIME_W-1:0]    cur_per;
  logic [TIME_W-1:0]    dec_val;
  logic                 walk_end;

  // word layout: period in the upper half, countdown in the lower half
  ptts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TASKS),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_ext  = EXT_W'(in_task_index);
  assign slot_sel = idx_ext[IDX_W-1:0];
  assign in_range = int'(in_task_index) < TASKS;

  // a never-written entry reads as a zero countdown
  assign cur_cd   = slot_wr_r[p_idx_r] ? ram_rdata[TIME_W-1:0] : '0;
  assign cur_per  = ram_rdata[WORD_W-1:TIME_W];
  // one decrementer: reload from period at zero, else count down
  assign dec_val  = ((cur_cd == '0) ? cur_per : cur_cd) - TIME_W'(1);
  assign walk_end = (rd_cnt_r == CNT_W'(TASKS));

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_fire_mask = out_fire_mask_r;
  assign out_accepted  = out_accepted_r;

  always_comb begin
    state_nxt         = state_r;
    rd_cnt_nxt        = rd_cnt_r;
    p_vld_nxt         = p_vld_r;
    p_idx_nxt         = p_idx_r;
    mask_nxt          = mask_r;
    res_acc_nxt       = res_acc_r;
    out_valid_nxt     = out_valid_r;
    out_fire_mask_nxt = out_fire_mask_r;
    out_accepted_nxt  = out_accepted_r;
    slot_valid_nxt    = slot_valid_r;
    slot_run_nxt      = slot_run_r;
    slot_wr_nxt       = slot_wr_r;
    ram_we            = 1'b0;
    ram_waddr         = slot_sel;
    ram_wdata         = {in_period, in_first_delay};
    ram_raddr         = rd_cnt_r[IDX_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mask_nxt = '0;
          if (in_op == OP_TICK) begin
            rd_cnt_nxt  = '0;
            p_vld_nxt   = 1'b0;
            res_acc_nxt = 1'b1;
            state_nxt   = ST_TICK;
          end else begin
            res_acc_nxt = 1'b0;
            state_nxt   = ST_DONE;
            if (in_range) begin
              case (in_op)
                OP_CREATE: begin
                  if (!slot_valid_r[slot_sel]) begin
                    slot_valid_nxt[slot_sel] = 1'b1;
                    slot_run_nxt[slot_sel]   = 1'b1;
                    slot_wr_nxt[slot_sel]    = 1'b1;
                    ram_we                   = 1'b1;
                    res_acc_nxt              = 1'b1;
                  end
                end
                OP_SUSPEND: begin
                  slot_run_nxt[slot_sel] = 1'b0;
                  res_acc_nxt            = 1'b1;
                end
                OP_RESUME: begin
                  slot_run_nxt[slot_sel] = 1'b1;
                  res_acc_nxt            = 1'b1;
                end
                OP_DELETE: begin
                  slot_valid_nxt[slot_sel] = 1'b0;
                  res_acc_nxt              = 1'b1;
                end
                default: begin
                  res_acc_nxt = 1'b0;
                end
              endcase
            end
          end
        end
      end

      ST_TICK: begin
        // issue the read of the next slot while the previous one writes back
        if (!walk_end) begin
          p_vld_nxt  = 1'b1;
          p_idx_nxt  = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end else begin
          p_vld_nxt = 1'b0;
        end

        if (p_vld_r && slot_run_r[p_idx_r]) begin
          ram_waddr = p_idx_r;
          if (cur_cd == '0) begin
            if (slot_valid_r[p_idx_r]) begin
              // slots past the mask width shift out and are not reported
              mask_nxt  = mask_r | (FIRE_W'(1) << p_idx_r);
              ram_we    = 1'b1;
              ram_wdata = {cur_per, dec_val};
            end
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {cur_per, dec_val};
          end
        end

        if (!p_vld_r && walk_end) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_fire_mask_nxt = mask_r;
          out_accepted_nxt  = res_acc_r;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_cnt_r     <= '0;
      p_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      slot_valid_r <= '0;
      slot_run_r   <= '0;
      slot_wr_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      p_vld_r      <= p_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      slot_valid_r <= slot_valid_nxt;
      slot_run_r   <= slot_run_nxt;
      slot_wr_r    <= slot_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r         <= p_idx_nxt;
    mask_r          <= mask_nxt;
    res_acc_r       <= res_acc_nxt;
    out_fire_mask_r <= out_fire_mask_nxt;
    out_accepted_r  <= out_accepted_nxt;
  end

`include "periodic_task_tick_scheduler_assert.svh"

  `PTTS_ASSERT_IMP(a_valid_implies_written, 1'b1, (slot_valid_r & ~slot_wr_r) == '0,
    "valid slot without a written ram entry")

  `PTTS_ASSERT_IMP(a_walk_index_in_range, p_vld_r, int'(p_idx_r) < TASKS,
    "tick walk index beyond the slot table")

  `PTTS_ASSERT_NXT(a_walk_finishes, (state_r == ST_TICK) && !p_vld_r && walk_end,
    state_r == ST_DONE, "tick walk did not hand over to result stage")

  `PTTS_ASSERT_NXT(a_non_tick_mask_zero, in_valid && in_ready && (in_op != OP_TICK),
    (state_r == ST_DONE) && (mask_r == '0), "non-tick request carries a fire mask")

endmodule

// ===== hw/rtl/ptts_ram.sv =====
// ----------------------------------------------------------------------------
// ptts_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ptts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the periodic task tick scheduler
// ----------------------------------------------------------------------------
// A short table of directed requests covers empty ticks, unused op codes,
// create into free and taken slots, suspend, resume, delete, zero period and
// a task that runs without being valid. Random requests follow, with mostly
// small periods and delays so that tasks fire often. A built-in slot model
// computes the fire mask and accepted flag of every accepted request, and
// each result is compared in order. The sender and receiver idle and stall
// in several mixes.
// ----------------------------------------------------------------------------
module testbench;
  import ptts_pkg::*;

  localparam int SLOTS        = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 360;
  localparam int SETTLE       = 20;
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [FIRE_W-1:0] fire_mask;
    logic              accepted;
  } outcome_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [TIDX_W-1:0] idx;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] dly;
    bit                typed;
    logic [FIRE_W-1:0] mask;
    logic              acc;
  } request_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op = '0;
  logic [TIDX_W-1:0] in_task_index = '0;
  logic [TIME_W-1:0] in_period = '0;
  logic [TIME_W-1:0] in_first_delay = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [FIRE_W-1:0] out_fire_mask;
  logic              out_accepted;

  // slot table copy
  bit                slot_live [SLOTS] = '{default: 1'b0};
  bit                slot_run  [SLOTS] = '{default: 1'b0};
  logic [TIME_W-1:0] slot_count [SLOTS] = '{default: '0};
  logic [TIME_W-1:0] slot_per   [SLOTS] = '{default: '0};

  outcome_t outcome_q [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int n_requests = 0;
  int n_ticks    = 0;
  int n_fired    = 0;
  int n_results  = 0;
  int cycle_count = 0;

  request_row_t directed_rows [0:24] = '{
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{OP_SPARE_LO,3'd0, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0},
    '{OP_SPARE_HI,3'd7, 16'hffff, 16'hffff, 1'b1, 8'h00, 1'b0},
    '{OP_SPARE_MID,3'd2, 16'h5555, 16'haaaa, 1'b1, 8'h00, 1'b0},
    '{OP_CREATE,  3'd0, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{OP_CREATE,  3'd0, 16'h0003, 16'h0003, 1'b1, 8'h00, 1'b0},
    '{OP_CREATE,  3'd7, 16'hffff, 16'hffff, 1'b1, 8'h00, 1'b1},
    '{OP_CREATE,  3'd3, 16'h0001, 16'h0001, 1'b1, 8'h00, 1'b1},
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{OP_TICK,    3'd5, 16'h1234, 16'h4321, 1'b0, 8'h00, 1'b0},
    '{OP_SUSPEND, 3'd3, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{OP_RESUME,  3'd3, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{OP_DELETE,  3'd0, 16'hffff, 16'hffff, 1'b1, 8'h00, 1'b1},
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{OP_RESUME,  3'd5, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{OP_CREATE,  3'd0, 16'h0002, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{OP_DELETE,  3'd7, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{OP_CREATE,  3'd7, 16'h0001, 16'h0000, 1'b1, 8'h00, 1'b1},
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}
  };

  periodic_task_tick_scheduler #(
    .TASKS(SLOTS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_task_index  (in_task_index),
    .in_period      (in_period),
    .in_first_delay (in_first_delay),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_fire_mask  (out_fire_mask),
    .out_accepted   (out_accepted)
  );

  always #5 clk = ~clk;

  // applies one request to the slot table, returns what the block reports
  function automatic outcome_t apply_request(logic [OP_W-1:0] op, logic [TIDX_W-1:0] idx,
                                             logic [TIME_W-1:0] per,
                                             logic [TIME_W-1:0] dly);
    outcome_t r;
    r.fire_mask = '0;
    r.accepted  = 1'b0;
    if (op == OP_TICK) begin
      r.accepted = 1'b1;
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_run[s]) begin
          if (slot_count[s] == '0) begin
            // a running but deleted slot parks at zero and never fires
            if (slot_live[s]) begin
              if (s < FIRE_W) r.fire_mask[s] = 1'b1;
              slot_count[s] = slot_per[s] - 16'd1;
            end
          end else begin
            slot_count[s] = slot_count[s] - 16'd1;
          end
        end
      end
    end else if (op <= OP_DELETE && int'(idx) < SLOTS) begin
      case (op)
        OP_CREATE: begin
          if (!slot_live[idx]) begin
            slot_live[idx]  = 1'b1;
            slot_run[idx]   = 1'b1;
            slot_per[idx]   = per;
            slot_count[idx] = dly;
            r.accepted      = 1'b1;
          end
        end
        OP_SUSPEND: begin
          slot_run[idx] = 1'b0;
          r.accepted    = 1'b1;
        end
        OP_RESUME: begin
          slot_run[idx] = 1'b1;
          r.accepted    = 1'b1;
        end
        default: begin
          slot_live[idx] = 1'b0;
          r.accepted     = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  // drives one request from a falling edge, returns at the falling edge after it is accepted
  task automatic send_request(logic [OP_W-1:0] op, logic [TIDX_W-1:0] idx,
                              logic [TIME_W-1:0] per, logic [TIME_W-1:0] dly,
                              bit typed, outcome_t typed_outcome);
    outcome_t model;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_op          = op;
    in_task_index  = idx;
    in_period      = per;
    in_first_delay = dly;
    do @(posedge clk); while (!in_ready);
    model = apply_request(op, idx, per, dly);
    outcome_q.push_back(typed ? typed_outcome : model);
    n_requests++;
    if (op == OP_TICK) n_ticks++;
    @(negedge clk);
  endtask

  task automatic send_random;
    int pick;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] dly;
    pick = $urandom_range(99);
    if      (pick < 45) op = OP_TICK;
    else if (pick < 65) op = OP_CREATE;
    else if (pick < 73) op = OP_SUSPEND;
    else if (pick < 83) op = OP_RESUME;
    else if (pick < 95) op = OP_DELETE;
    else                op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    // short periods keep tasks firing, the odd full-range one exercises wide values
    per = ($urandom_range(99) < 85) ? TIME_W'($urandom_range(0, 9)) : TIME_W'($urandom);
    dly = ($urandom_range(99) < 85) ? TIME_W'($urandom_range(0, 9)) : TIME_W'($urandom);
    send_request(op, TIDX_W'($urandom_range(0, SLOTS - 1)), per, dly, 1'b0, '0);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      n_fired += $countones(out_fire_mask);
      if (outcome_q.size() == 0) begin
        $error("result with no request pending: fire_mask %0h accepted %0b",
               out_fire_mask, out_accepted);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (out_fire_mask !== want.fire_mask) begin
          $error("fire_mask: expected %0h, got %0h", want.fire_mask, out_fire_mask);
          errors++;
        end
        if (out_accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, out_accepted);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count, outcome_q.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    outcome_t typed_outcome;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table, no idling
    foreach (directed_rows[i]) begin
      typed_outcome.fire_mask = directed_rows[i].mask;
      typed_outcome.accepted  = directed_rows[i].acc;
      send_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].per,
                   directed_rows[i].dly, directed_rows[i].typed, typed_outcome);
    end
    drain();

    // random mixes, the sender holds off until everything is back between them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      repeat (PHASE_ITEMS) send_random();
      drain();
    end

    stall_pct = 0;
    repeat (SETTLE) @(negedge clk);
    if (outcome_q.size() != 0) begin
      $error("%0d results never arrived", outcome_q.size());
      errors++;
    end
    $display("ran %0d requests (%0d ticks), %0d results back, %0d task firings seen",
             n_requests, n_ticks, n_results, n_fired);
    $display("idle mixes: none, sender 52%%, receiver 52%%, both 31%%");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== periodic_task_tick_scheduler.f =====
+incdir+hw/rtl
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_ram.sv
hw/rtl/periodic_task_tick_scheduler.sv
tb/testbench.sv
